// ----- sv/ata_pkg.sv -----
// ----------------------------------------------------------------------------
// ata_pkg
// Constants shared by the tilt angle pipeline: angle format and CORDIC table.
// ----------------------------------------------------------------------------
package ata_pkg;

   localparam int ANG_W         = 29;
   localparam int OUT_W         = 12;
   localparam int FRAC_SHIFT    = 16;
   localparam int CORDIC_STAGES = 21;
   localparam int LANES         = 3;

   // angles in 2^-20 degree
   localparam logic signed [ANG_W-1:0] DEG_90  = 29'sd94371840;
   localparam logic        [ANG_W-2:0] DEG_180 = 28'd188743680;

   localparam logic signed [ANG_W-1:0] ATAN_TAB [0:CORDIC_STAGES-1] = '{
      29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121, 29'sd3750058,
      29'sd1876857,  29'sd938658,   29'sd469357,   29'sd234682,  29'sd117342,
      29'sd58671,    29'sd29335,    29'sd14668,    29'sd7334,    29'sd3667,
      29'sd1833,     29'sd917,      29'sd458,      29'sd229,     29'sd115,
      29'sd57
   };

   // first-quadrant angle with special cases and clamp applied
   function automatic logic [ANG_W-2:0] quad_angle(logic signed [ANG_W-1:0] z,
                                                    logic num_zero, logic den_zero);
      logic [ANG_W-2:0] q;
      if (num_zero) begin
         q = '0;
      end else if (den_zero) begin
         q = DEG_90[ANG_W-2:0];
      end else if (z < 0) begin
         q = '0;
      end else if (z > DEG_90) begin
         q = DEG_90[ANG_W-2:0];
      end else begin
         q = z[ANG_W-2:0];
      end
      return q;
   endfunction

endpackage

// ----- sv/ata_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// ata_sqrt_cell
// One digit of a pipelined restoring square root: two radicand bits per cell.
// ----------------------------------------------------------------------------
module ata_sqrt_cell
   import ata_pkg::*;
#(
   parameter int RW = 30,
   parameter int NW = 60
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW+2:0] rem_i,
   input  logic [RW-1:0] root_i,
   input  logic [NW-1:0] n_i,
   output logic [RW+2:0] rem_ff,
   output logic [RW-1:0] root_ff,
   output logic [NW-1:0] n_ff
);

   logic [RW+2:0] cur;
   logic [RW+2:0] trial;
   logic          ge;
   logic [RW+2:0] rem_in;
   logic [RW-1:0] root_in;
   logic [NW-1:0] n_in;

   always_comb begin
      cur     = {rem_i[RW:0], n_i[NW-1 -: 2]};
      trial   = {1'b0, root_i, 2'b01};
      ge      = (cur >= trial);
      rem_in  = ge ? (cur - trial) : cur;
      root_in = {root_i[RW-2:0], ge};
      n_in    = {n_i[NW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         n_ff    <= n_in;
      end
   end

endmodule

// ----- sv/ata_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// ata_cordic_cell
// One vectoring CORDIC rotation with a fixed shift and table angle.
// ----------------------------------------------------------------------------
module ata_cordic_cell
   import ata_pkg::*;
#(
   parameter int                      CW    = 34,
   parameter int                      SHIFT = 0,
   parameter logic signed [ANG_W-1:0] ANGLE = '0
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [CW-1:0]    x_i,
   input  logic signed [CW-1:0]    y_i,
   input  logic signed [ANG_W-1:0] z_i,
   input  logic                    nz_i,
   input  logic                    dz_i,
   output logic signed [CW-1:0]    x_ff,
   output logic signed [CW-1:0]    y_ff,
   output logic signed [ANG_W-1:0] z_ff,
   output logic                    nz_ff,
   output logic                    dz_ff
);

   localparam logic signed [CW-1:0] RND = CW'((64'd1 << SHIFT) - 64'd1);

   logic signed [CW-1:0]    dx;
   logic signed [CW-1:0]    dy;
   logic signed [CW-1:0]    x_in;
   logic signed [CW-1:0]    y_in;
   logic signed [ANG_W-1:0] z_in;

   // shifts truncate toward zero
   always_comb begin
      dx = $signed(y_i + ((y_i < 0) ? RND : '0)) >>> SHIFT;
      dy = $signed(x_i + ((x_i < 0) ? RND : '0)) >>> SHIFT;
      if (y_i > 0) begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ANGLE;
      end else begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         nz_ff <= nz_i;
         dz_ff <= dz_i;
      end
   end

endmodule

// ----- sv/accel_tilt_angles_top.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Pitch, roll and tilt from one accelerometer sample: squares, three
// pipelined square roots, three pipelined CORDIC lanes.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_accel_x/y/z
//   rsp     | out       | rsp_valid, rsp_ready, rsp_pitch_angle, rsp_roll_angle,
//           |           | rsp_tilt_from_vertical
//
// one request per cycle while req_ready is high; each lane has SAMPLE_WIDTH + 16
// square root cells and 21 CORDIC cells
// the pipeline advances as one; a skid register behind the output register
// takes the result that arrives during a stall, then req_ready drops
// reset clears all valid bits, those of the output and skid registers included
// ----------------------------------------------------------------------------
module accel_tilt_angles_top
   import ata_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_W-1:0]        rsp_pitch_angle,
   output logic signed [OUT_W-1:0]        rsp_roll_angle,
   output logic        [OUT_W-1:0]        rsp_tilt_from_vertical
);

   localparam int W   = SAMPLE_WIDTH;
   localparam int SW  = 2 * W;
   localparam int RW  = W + FRAC_SHIFT;
   localparam int NW  = SW + 2 * FRAC_SHIFT;
   localparam int CW  = RW + 4;
   localparam int CS  = CORDIC_STAGES;
   localparam int SQ0 = 3;
   localparam int DST = SQ0 + RW;
   localparam int NST = DST + CS + 2;

   logic en;
   logic accept;
   logic [NST-1:0] v_ff;

   logic signed [W-1:0] smp_x_ff [0:NST-2];
   logic signed [W-1:0] smp_y_ff [0:NST-2];
   logic signed [W-1:0] smp_z_ff [0:NST-2];

   logic [SW-1:0] xx_ff, yy_ff, zz_ff;
   logic [SW-1:0] sum_ff [0:LANES-1];

   logic [RW+2:0] sq_rem  [0:LANES-1][0:RW];
   logic [RW-1:0] sq_root [0:LANES-1][0:RW];
   logic [NW-1:0] sq_n    [0:LANES-1][0:RW];

   logic signed [CW-1:0]    cx  [0:LANES-1][0:CS];
   logic signed [CW-1:0]    cy  [0:LANES-1][0:CS];
   logic signed [ANG_W-1:0] cz  [0:LANES-1][0:CS];
   logic                    cnz [0:LANES-1][0:CS];
   logic                    cdz [0:LANES-1][0:CS];

   logic [W-1:0] ax, ay, az;
   logic [RW-1:0] num_p, num_r, den_t;

   logic [ANG_W-2:0] q_p, q_r, q_t;
   logic [ANG_W-2:0] t_neg;
   logic signed [OUT_W-1:0] pitch_in, roll_in;
   logic        [OUT_W-1:0] tilt_in;
   logic signed [OUT_W-1:0] p_pitch_ff, p_roll_ff;
   logic        [OUT_W-1:0] p_tilt_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic skid_v_ff, skid_v_in;
   logic signed [OUT_W-1:0] rsp_pitch_ff, rsp_roll_ff, skid_pitch_ff, skid_roll_ff;
   logic        [OUT_W-1:0] rsp_tilt_ff, skid_tilt_ff;
   logic leave, out_free;

   assign en        = ~skid_v_ff;
   assign req_ready = en;
   assign accept    = req_valid & en;

   // valid bits and sample side line
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smp_x_ff[0] <= req_accel_x;
         smp_y_ff[0] <= req_accel_y;
         smp_z_ff[0] <= req_accel_z;
         for (int k = 1; k < NST - 1; k++) begin
            smp_x_ff[k] <= smp_x_ff[k-1];
            smp_y_ff[k] <= smp_y_ff[k-1];
            smp_z_ff[k] <= smp_z_ff[k-1];
         end
      end
   end

   // squares, then sums of pairs
   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff     <= SW'(smp_x_ff[0]) * SW'(smp_x_ff[0]);
         yy_ff     <= SW'(smp_y_ff[0]) * SW'(smp_y_ff[0]);
         zz_ff     <= SW'(smp_z_ff[0]) * SW'(smp_z_ff[0]);
         sum_ff[0] <= yy_ff + zz_ff;
         sum_ff[1] <= xx_ff + zz_ff;
         sum_ff[2] <= xx_ff + yy_ff;
      end
   end

   // square root lanes: yz, xz, xy
   genvar l, k;
   generate
      for (l = 0; l < LANES; l++) begin : g_sq
         assign sq_rem[l][0]  = '0;
         assign sq_root[l][0] = '0;
         assign sq_n[l][0]    = {sum_ff[l], {(2*FRAC_SHIFT){1'b0}}};
         for (k = 0; k < RW; k++) begin : g_cell
            ata_sqrt_cell #(.RW(RW), .NW(NW)) u_cell (
               .clock   (clock),
               .en      (en),
               .rem_i   (sq_rem[l][k]),
               .root_i  (sq_root[l][k]),
               .n_i     (sq_n[l][k]),
               .rem_ff  (sq_rem[l][k+1]),
               .root_ff (sq_root[l][k+1]),
               .n_ff    (sq_n[l][k+1])
            );
         end
      end
   endgenerate

   // cordic operands: pitch, roll, tilt
   always_comb begin
      ax    = smp_x_ff[DST-1][W-1] ? W'(-smp_x_ff[DST-1]) : W'(smp_x_ff[DST-1]);
      ay    = smp_y_ff[DST-1][W-1] ? W'(-smp_y_ff[DST-1]) : W'(smp_y_ff[DST-1]);
      az    = smp_z_ff[DST-1][W-1] ? W'(-smp_z_ff[DST-1]) : W'(smp_z_ff[DST-1]);
      num_p = {ax, {FRAC_SHIFT{1'b0}}};
      num_r = {ay, {FRAC_SHIFT{1'b0}}};
      den_t = {az, {FRAC_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx[0][0]  <= CW'(sq_root[0][RW]);
         cy[0][0]  <= CW'(num_p);
         cnz[0][0] <= (num_p == '0);
         cdz[0][0] <= (sq_root[0][RW] == '0);
         cx[1][0]  <= CW'(sq_root[1][RW]);
         cy[1][0]  <= CW'(num_r);
         cnz[1][0] <= (num_r == '0);
         cdz[1][0] <= (sq_root[1][RW] == '0);
         cx[2][0]  <= CW'(den_t);
         cy[2][0]  <= CW'(sq_root[2][RW]);
         cnz[2][0] <= (sq_root[2][RW] == '0);
         cdz[2][0] <= (den_t == '0);
         cz[0][0]  <= '0;
         cz[1][0]  <= '0;
         cz[2][0]  <= '0;
      end
   end

   generate
      for (l = 0; l < LANES; l++) begin : g_cr
         for (k = 0; k < CS; k++) begin : g_cell
            ata_cordic_cell #(.CW(CW), .SHIFT(k), .ANGLE(ATAN_TAB[k])) u_cell (
               .clock (clock),
               .en    (en),
               .x_i   (cx[l][k]),
               .y_i   (cy[l][k]),
               .z_i   (cz[l][k]),
               .nz_i  (cnz[l][k]),
               .dz_i  (cdz[l][k]),
               .x_ff  (cx[l][k+1]),
               .y_ff  (cy[l][k+1]),
               .z_ff  (cz[l][k+1]),
               .nz_ff (cnz[l][k+1]),
               .dz_ff (cdz[l][k+1])
            );
         end
      end
   endgenerate

   // final angles
   always_comb begin
      q_p   = quad_angle(cz[0][CS], cnz[0][CS], cdz[0][CS]);
      q_r   = quad_angle(cz[1][CS], cnz[1][CS], cdz[1][CS]);
      q_t   = quad_angle(cz[2][CS], cnz[2][CS], cdz[2][CS]);
      t_neg = DEG_180 - q_t;
      pitch_in = smp_x_ff[NST-2][W-1] ? -OUT_W'(q_p[ANG_W-2:FRAC_SHIFT])
                                      : OUT_W'(q_p[ANG_W-2:FRAC_SHIFT]);
      roll_in  = smp_y_ff[NST-2][W-1] ? -OUT_W'(q_r[ANG_W-2:FRAC_SHIFT])
                                      : OUT_W'(q_r[ANG_W-2:FRAC_SHIFT]);
      if (smp_x_ff[NST-2] == '0 && smp_y_ff[NST-2] == '0 && smp_z_ff[NST-2] == '0) begin
         tilt_in = '0;
      end else if (smp_z_ff[NST-2][W-1]) begin
         tilt_in = OUT_W'(t_neg[ANG_W-2:FRAC_SHIFT]);
      end else begin
         tilt_in = OUT_W'(q_t[ANG_W-2:FRAC_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_pitch_ff <= pitch_in;
         p_roll_ff  <= roll_in;
         p_tilt_ff  <= tilt_in;
      end
   end

   // output register and skid
   always_comb begin
      leave    = en & v_ff[NST-1];
      out_free = ~rsp_valid_ff | rsp_ready;
      if (out_free) begin
         rsp_valid_in = skid_v_ff | leave;
      end else begin
         rsp_valid_in = 1'b1;
      end
      if (skid_v_ff) begin
         skid_v_in = ~out_free;
      end else begin
         skid_v_in = leave & ~out_free;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_v_ff    <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_v_ff) begin
            rsp_pitch_ff <= skid_pitch_ff;
            rsp_roll_ff  <= skid_roll_ff;
            rsp_tilt_ff  <= skid_tilt_ff;
         end else begin
            rsp_pitch_ff <= p_pitch_ff;
            rsp_roll_ff  <= p_roll_ff;
            rsp_tilt_ff  <= p_tilt_ff;
         end
      end
      if (!skid_v_ff && leave && !out_free) begin
         skid_pitch_ff <= p_pitch_ff;
         skid_roll_ff  <= p_roll_ff;
         skid_tilt_ff  <= p_tilt_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_pitch_angle        = rsp_pitch_ff;
   assign rsp_roll_angle         = rsp_roll_ff;
   assign rsp_tilt_from_vertical = rsp_tilt_ff;

endmodule

// ----- sv/ata_checker.sv -----
// ----------------------------------------------------------------------------
// ata_checker
// Port-level checks on the tilt angle block, bound to the top level.
// ----------------------------------------------------------------------------
module ata_checker
   import ata_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 14
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic signed [SAMPLE_WIDTH-1:0] req_accel_x,
   input logic signed [SAMPLE_WIDTH-1:0] req_accel_y,
   input logic signed [SAMPLE_WIDTH-1:0] req_accel_z,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [OUT_W-1:0]        rsp_pitch_angle,
   input logic signed [OUT_W-1:0]        rsp_roll_angle,
   input logic        [OUT_W-1:0]        rsp_tilt_from_vertical
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch_angle)
         && $stable(rsp_roll_angle) && $stable(rsp_tilt_from_vertical))
      else $error("stalled response changed");

   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tilt_from_vertical <= 12'd2880)
      else $error("tilt out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle >= -12'sd1440 && rsp_pitch_angle <= 12'sd1440
         && rsp_roll_angle >= -12'sd1440 && rsp_roll_angle <= 12'sd1440))
      else $error("pitch or roll out of range");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && $past(rsp_valid && !rsp_ready))
      else $error("request side stalled without a held response");

endmodule

bind accel_tilt_angles_top ata_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ata_checker (.*);

// ----- bench/tb_accel_tilt_angles_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles_top
// Self-checking bench for the tilt angle pipeline. Samples are queued by an
// initial block, sent by a clocked driver with random gaps, and every response
// is checked in order against an integer model of the square roots and the
// CORDIC angle search, under random output stalls.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles_top
   import ata_pkg::*;
();

   localparam int SW = 14;
   localparam int RUN_LIMIT = 400000;

   typedef struct packed {
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
      logic signed [SW-1:0] z;
   } sample_type;

   typedef struct packed {
      logic [OUT_W-1:0] pitch;
      logic [OUT_W-1:0] roll;
      logic [OUT_W-1:0] tilt;
   } angles_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [SW-1:0] req_accel_x;
   logic signed [SW-1:0] req_accel_y;
   logic signed [SW-1:0] req_accel_z;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [OUT_W-1:0] rsp_pitch_angle;
   logic signed [OUT_W-1:0] rsp_roll_angle;
   logic        [OUT_W-1:0] rsp_tilt_from_vertical;

   sample_type samples_to_send[$];
   angles_type angles_due[$];
   int      mismatches;
   int      cycle_count = 0;
   int      send_gap;
   int      stall_len;

   accel_tilt_angles_top #(.SAMPLE_WIDTH(SW)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_roll_angle(rsp_roll_angle),
      .rsp_tilt_from_vertical(rsp_tilt_from_vertical)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // vectoring CORDIC, result in 2^-20 degree clamped to 0..90
   function automatic longint quadrant_angle(longint num, longint den);
      longint cx, cy, cz, dx, dy, div;
      cx = den;
      cy = num;
      cz = 0;
      if (num == 0) return 0;
      if (den == 0) return longint'(DEG_90);
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         div = longint'(1) << i;
         dx = cy / div;
         dy = cx / div;
         if (cy > 0) begin
            cx = cx + dx;
            cy = cy - dy;
            cz = cz + longint'(ATAN_TAB[i]);
         end else begin
            cx = cx - dx;
            cy = cy + dy;
            cz = cz - longint'(ATAN_TAB[i]);
         end
      end
      if (cz < 0) cz = 0;
      if (cz > longint'(DEG_90)) cz = longint'(DEG_90);
      return cz;
   endfunction

   function automatic longint axis_angle(longint num, longint den);
      longint mag, a;
      mag = num < 0 ? -num : num;
      a = quadrant_angle(mag << 16, den) >>> 16;
      return num < 0 ? -a : a;
   endfunction

   function automatic angles_type tilt_angles(sample_type s);
      longint x, y, z, r_yz, r_xz, r_xy, az, q, tilt, pitch, roll;
      logic [63:0] xx, yy, zz;
      angles_type a;
      x = s.x;
      y = s.y;
      z = s.z;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      r_yz = floor_sqrt((yy + zz) << 32);
      r_xz = floor_sqrt((xx + zz) << 32);
      r_xy = floor_sqrt((xx + yy) << 32);
      pitch = axis_angle(x, r_yz);
      roll = axis_angle(y, r_xz);
      az = z < 0 ? -z : z;
      q = quadrant_angle(r_xy, az << 16);
      if (r_xy == 0 && z == 0) tilt = 0;
      else if (z < 0) tilt = (longint'(DEG_180) - q) >>> 16;
      else tilt = q >>> 16;
      a.pitch = pitch[OUT_W-1:0];
      a.roll = roll[OUT_W-1:0];
      a.tilt = tilt[OUT_W-1:0];
      return a;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 3);
      return 0;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch in %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic add_sample(int x, int y, int z);
      sample_type s;
      s.x = SW'(x);
      s.y = SW'(y);
      s.z = SW'(z);
      samples_to_send.push_back(s);
   endtask

   function automatic int rand_axis();
      case ($urandom_range(0, 3))
         0: return $signed($urandom_range(0, 16383)) - 8192;
         1: return $signed($urandom_range(0, 64)) - 32;
         2: return $urandom_range(0, 1) ? 8191 - $urandom_range(0, 3)
                                         : -8192 + $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      sample_type s;
      logic    sent;
      sent = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || sent) begin
         if (sent) angles_due.push_back(tilt_angles({req_accel_x, req_accel_y,
                                                     req_accel_z}));
         if (send_gap == 0 && samples_to_send.size() > 0) begin
            s = samples_to_send.pop_front();
            req_valid <= 1'b1;
            req_accel_x <= s.x;
            req_accel_y <= s.y;
            req_accel_z <= s.z;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      angles_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_len <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (angles_due.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = angles_due.pop_front();
               if (rsp_pitch_angle !== want.pitch)
                  report_mismatch("pitch", rsp_pitch_angle, $signed(want.pitch));
               if (rsp_roll_angle !== want.roll)
                  report_mismatch("roll", rsp_roll_angle, $signed(want.roll));
               if (rsp_tilt_from_vertical !== want.tilt)
                  report_mismatch("tilt", rsp_tilt_from_vertical, want.tilt);
            end
         end
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            stall_len <= stall_len - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall_len <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      send_gap = 0;
      stall_len = 0;
      // all-zero, zero numerators, zero denominators, extremes
      add_sample(0, 0, 0);
      add_sample(0, 0, 1);
      add_sample(0, 0, -1);
      add_sample(0, 0, 8191);
      add_sample(0, 0, -8192);
      add_sample(8191, 0, 0);
      add_sample(-8192, 0, 0);
      add_sample(0, 8191, 0);
      add_sample(0, -8192, 0);
      add_sample(1, 0, 0);
      add_sample(0, -1, 0);
      add_sample(-8192, -8192, -8192);
      add_sample(8191, 8191, 8191);
      add_sample(8191, -8192, 8191);
      add_sample(-8192, 8191, -8192);
      add_sample(1, 1, 1);
      add_sample(-1, -1, -1);
      add_sample(1, 8191, -8192);
      add_sample(-8192, 1, 8191);
      add_sample(100, 100, 0);
      add_sample(-5461, 0, -5461);
      add_sample(0, 1, -8192);
      for (int i = 0; i < 850; i++) add_sample(rand_axis(), rand_axis(), rand_axis());
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (samples_to_send.size() == 0 && !req_valid && angles_due.size() == 0);
      repeat (120) @(posedge clock);
      if (mismatches == 0 && angles_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/ata_pkg.sv
sv/ata_sqrt_cell.sv
sv/ata_cordic_cell.sv
sv/accel_tilt_angles_top.sv
sv/ata_checker.sv
bench/tb_accel_tilt_angles_top.sv
